@@ sv/dsa_pkg.sv @@
`timescale 1ns / 1ps

package dsa_pkg;

	localparam int DEPTH_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_ADDR_W     = 2;
	localparam int ANGLE_W        = 8;
	localparam int MASK_W         = 5;
	localparam int EDGE_W         = 4;
	localparam int FRAC_BITS      = 16;
	localparam int MICRO_W        = 20;
	localparam int TAN_W          = 26;
	localparam int TAN_STEPS      = 89;
	localparam int STEP_W         = 7;
	localparam int SEARCH_STEPS   = 7;
	localparam int SEARCH_LAT     = 2 * SEARCH_STEPS;

	localparam logic [MICRO_W-1:0] MICRO = MICRO_W'(1000000);

	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HSCALE    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VSCALE    = 2'd2;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd800;
	localparam logic [CFG_W-1:0] HSCALE_RST    = 16'd415;
	localparam logic [CFG_W-1:0] VSCALE_RST    = 16'd429;

	localparam logic [ANGLE_W-1:0] ANGLE_MID     = 8'd90;
	localparam logic [ANGLE_W-1:0] ANGLE_INVALID = 8'd255;
	localparam logic [STEP_W-1:0]  STEP_LAST     = STEP_W'(TAN_STEPS);

	// tan(j degrees) in millionths, j = 1..89.
	localparam logic [TAN_W-1:0] TAN_MICRO [0:TAN_STEPS-1] = '{
		26'd17455, 26'd34921, 26'd52408, 26'd69927, 26'd87489,
		26'd105104, 26'd122785, 26'd140541, 26'd158384, 26'd176327,
		26'd194380, 26'd212557, 26'd230868, 26'd249328, 26'd267949,
		26'd286745, 26'd305731, 26'd324920, 26'd344328, 26'd363970,
		26'd383864, 26'd404026, 26'd424475, 26'd445229, 26'd466308,
		26'd487733, 26'd509525, 26'd531709, 26'd554309, 26'd577350,
		26'd600861, 26'd624869, 26'd649408, 26'd674509, 26'd700208,
		26'd726543, 26'd753554, 26'd781286, 26'd809784, 26'd839100,
		26'd869287, 26'd900404, 26'd932515, 26'd965689, 26'd1000000,
		26'd1035530, 26'd1072369, 26'd1110613, 26'd1150368, 26'd1191754,
		26'd1234897, 26'd1279942, 26'd1327045, 26'd1376382, 26'd1428148,
		26'd1482561, 26'd1539865, 26'd1600335, 26'd1664279, 26'd1732051,
		26'd1804048, 26'd1880726, 26'd1962611, 26'd2050304, 26'd2144507,
		26'd2246037, 26'd2355852, 26'd2475087, 26'd2605089, 26'd2747477,
		26'd2904211, 26'd3077684, 26'd3270853, 26'd3487414, 26'd3732051,
		26'd4010781, 26'd4331476, 26'd4704630, 26'd5144554, 26'd5671282,
		26'd6313752, 26'd7115370, 26'd8144346, 26'd9514364, 26'd11430052,
		26'd14300666, 26'd19081137, 26'd28636253, 26'd57289962
	};

	typedef struct packed {
		logic valid;
		logic centre_ok;
		logic grad_ok;
		logic zero_x;
		logic neg_x;
		logic zero_y;
		logic neg_y;
	} dsa_flags_t;

endpackage

@@ sv/dsa_search.sv @@
`timescale 1ns / 1ps

// Finds the number of table angles whose tangent the ratio reaches,
// one bit of the count per two pipeline stages.
module dsa_search import dsa_pkg::*; #(
	parameter int MAG_W = DEPTH_BITS_DEF + 1
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [MAG_W+MICRO_W-1:0]     lhs,
	input  logic [MAG_W+CFG_W-1:0]       den,
	output logic [STEP_W-1:0]            count
);

	localparam int LHS_W = MAG_W + MICRO_W;
	localparam int DEN_W = MAG_W + CFG_W;
	localparam int PRD_W = TAN_W + DEN_W;

	logic [STEP_W-1:0]          k_sa    [SEARCH_STEPS];
	logic [STEP_W-1:0]          cand_sa [SEARCH_STEPS];
	logic                       cok_sa  [SEARCH_STEPS];
	logic [TAN_W+MAG_W-1:0]     plo_sa  [SEARCH_STEPS];
	logic [TAN_W+CFG_W-1:0]     phi_sa  [SEARCH_STEPS];
	logic [LHS_W-1:0]           lhs_sa  [SEARCH_STEPS];
	logic [DEN_W-1:0]           den_sa  [SEARCH_STEPS];
	logic [STEP_W-1:0]          k_sb    [SEARCH_STEPS];
	logic [LHS_W-1:0]           lhs_sb  [SEARCH_STEPS];
	logic [DEN_W-1:0]           den_sb  [SEARCH_STEPS];

	for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
		logic [STEP_W-1:0] k_in;
		logic [LHS_W-1:0]  lhs_in;
		logic [DEN_W-1:0]  den_in;
		logic [STEP_W-1:0] cand;
		logic              cok;
		logic [STEP_W-1:0] idx;
		logic [TAN_W-1:0]  tval;
		logic [PRD_W-1:0]  prod;
		logic [PRD_W-1:0]  lhs_full;

		if (i == 0) begin : g_first
			assign k_in   = '0;
			assign lhs_in = lhs;
			assign den_in = den;
		end else begin : g_next
			assign k_in   = k_sb[i-1];
			assign lhs_in = lhs_sb[i-1];
			assign den_in = den_sb[i-1];
		end

		always_comb begin
			cand = k_in | (STEP_W'(1) << (SEARCH_STEPS - 1 - i));
			cok  = cand <= STEP_LAST;
			idx  = cok ? cand - STEP_W'(1) : '0;
			tval = TAN_MICRO[idx];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_sa[i]    <= k_in;
				cand_sa[i] <= cand;
				cok_sa[i]  <= cok;
				plo_sa[i]  <= tval * den_in[MAG_W-1:0];
				phi_sa[i]  <= tval * den_in[DEN_W-1:MAG_W];
				lhs_sa[i]  <= lhs_in;
				den_sa[i]  <= den_in;
			end
		end

		always_comb begin
			prod     = {phi_sa[i], MAG_W'(0)} + PRD_W'(plo_sa[i]);
			lhs_full = PRD_W'({lhs_sa[i], FRAC_BITS'(0)});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_sb[i]   <= (cok_sa[i] && lhs_full >= prod) ? cand_sa[i] : k_sa[i];
				lhs_sb[i] <= lhs_sa[i];
				den_sb[i] <= den_sa[i];
			end
		end
	end

	assign count = k_sb[SEARCH_STEPS-1];

endmodule

@@ sv/depth_slope_angle.sv @@
`timescale 1ns / 1ps

// Surface slope angles from a depth neighbourhood. One item is taken in every
// clock cycle while the output side takes results; each item passes through
// three setup stages, the seven-step binary search over the tangent table,
// two stages per step, run for both axes side by side, and the output
// register. Configuration writes are always taken and should only be made
// while no item is in flight.
// DEPTH_BITS may be set from 11 to 16 and sets the width of every depth field.
module depth_slope_angle import dsa_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// centre_depth, left_depth, right_depth, upper_depth, lower_depth,
	// valid_mask, edge_mask, zero padding
	input  logic [((5*DEPTH_BITS+MASK_W+EDGE_W+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// angle_x, angle_y
	output logic [2*ANGLE_W-1:0]  m_tdata
);

	localparam int DW    = DEPTH_BITS;
	localparam int RW    = DW + 2;
	localparam int MW    = DW + 1;
	localparam int CMPW  = (RW > CFG_W + 1 ? RW : CFG_W + 1) + 1;

	logic [CFG_W-1:0] thr_q, hscale_q, vscale_q;
	logic             en;

	assign cfg_ready = 1'b1;
	assign en        = ~m_tvalid | m_tready;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RST;
			hscale_q <= HSCALE_RST;
			vscale_q <= VSCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q    <= cfg_data;
				REG_HSCALE:    hscale_q <= cfg_data;
				REG_VSCALE:    vscale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: replace missing neighbours and check the threshold.
	logic [DW-1:0]       c_in, l_in, r_in, u_in, d_in;
	logic [MASK_W-1:0]   vm;
	logic [EDGE_W-1:0]   em;
	logic signed [RW-1:0] c2, lv, rv, uv, dv;
	logic                lm, rm, um, dm, exist, above;
	logic signed [CMPW-1:0] thr_s;

	always_comb begin
		c_in = s_tdata[0*DW +: DW];
		l_in = s_tdata[1*DW +: DW];
		r_in = s_tdata[2*DW +: DW];
		u_in = s_tdata[3*DW +: DW];
		d_in = s_tdata[4*DW +: DW];
		vm   = s_tdata[5*DW +: MASK_W];
		em   = s_tdata[5*DW+MASK_W +: EDGE_W];
		lm   = em[0] | ~vm[1];
		rm   = em[1] | ~vm[2];
		um   = em[2] | ~vm[3];
		dm   = em[3] | ~vm[4];
		c2   = $signed({1'b0, c_in, 1'b0});
		lv   = lm ? c2 - $signed(RW'(r_in)) : $signed(RW'(l_in));
		rv   = rm ? c2 - $signed(RW'(l_in)) : $signed(RW'(r_in));
		uv   = um ? c2 - $signed(RW'(d_in)) : $signed(RW'(u_in));
		dv   = dm ? c2 - $signed(RW'(u_in)) : $signed(RW'(d_in));
		exist = ~(lm & rm) & ~(um & dm);
		thr_s = $signed(CMPW'(thr_q));
		above = (CMPW'(lv) >= thr_s) && (CMPW'(rv) >= thr_s)
			&& (CMPW'(uv) >= thr_s) && (CMPW'(dv) >= thr_s);
	end

	logic                 valid_s1, cv_s1, ok_s1;
	logic signed [RW-1:0] lv_s1, rv_s1, uv_s1, dv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cv_s1 <= vm[0];
			ok_s1 <= exist & above;
			lv_s1 <= lv;
			rv_s1 <= rv;
			uv_s1 <= uv;
			dv_s1 <= dv;
		end
	end

	// Stage 2: difference magnitude, larger value and sign per axis.
	logic signed [RW:0] dx, dy;
	logic               valid_s2, cv_s2, ok_s2;
	logic               neg_x_s2, zero_x_s2, neg_y_s2, zero_y_s2;
	logic [MW-1:0]      mag_x_s2, mx_x_s2, mag_y_s2, mx_y_s2;

	always_comb begin
		dx = (RW+1)'(lv_s1) - (RW+1)'(rv_s1);
		dy = (RW+1)'(uv_s1) - (RW+1)'(dv_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cv_s2     <= cv_s1;
			ok_s2     <= ok_s1;
			neg_x_s2  <= dx < 0;
			zero_x_s2 <= dx == 0;
			neg_y_s2  <= dy < 0;
			zero_y_s2 <= dy == 0;
			mag_x_s2  <= (dx < 0) ? MW'(-dx) : MW'(dx);
			mag_y_s2  <= (dy < 0) ? MW'(-dy) : MW'(dy);
			mx_x_s2   <= (lv_s1 > rv_s1) ? MW'(lv_s1) : MW'(rv_s1);
			mx_y_s2   <= (uv_s1 > dv_s1) ? MW'(uv_s1) : MW'(dv_s1);
		end
	end

	// Stage 3: both sides of the tangent comparison.
	dsa_flags_t              flags_s3;
	logic [MW+MICRO_W-1:0]   lhs_x_s3, lhs_y_s3;
	logic [MW+CFG_W-1:0]     den_x_s3, den_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s3 <= '0;
		end else if (en) begin
			flags_s3.valid     <= valid_s2;
			flags_s3.centre_ok <= cv_s2;
			flags_s3.grad_ok   <= ok_s2;
			flags_s3.zero_x    <= zero_x_s2;
			flags_s3.neg_x     <= neg_x_s2;
			flags_s3.zero_y    <= zero_y_s2;
			flags_s3.neg_y     <= neg_y_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_x_s3 <= mag_x_s2 * MICRO;
			lhs_y_s3 <= mag_y_s2 * MICRO;
			den_x_s3 <= mx_x_s2 * hscale_q;
			den_y_s3 <= mx_y_s2 * vscale_q;
		end
	end

	// Search stages.
	logic [STEP_W-1:0] k_x, k_y;
	dsa_flags_t        flags_q [SEARCH_LAT];

	dsa_search #(.MAG_W(MW)) u_search_x (
		.clk   (clk),
		.en    (en),
		.lhs   (lhs_x_s3),
		.den   (den_x_s3),
		.count (k_x)
	);

	dsa_search #(.MAG_W(MW)) u_search_y (
		.clk   (clk),
		.en    (en),
		.lhs   (lhs_y_s3),
		.den   (den_y_s3),
		.count (k_y)
	);

	for (genvar i = 0; i < SEARCH_LAT; i++) begin : g_flags
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_q[i] <= '0;
			end else if (en) begin
				flags_q[i] <= (i == 0) ? flags_s3 : flags_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Output register.
	dsa_flags_t        fo;
	logic [ANGLE_W-1:0] ax, ay;

	always_comb begin
		fo = flags_q[SEARCH_LAT-1];
		if (!fo.centre_ok) begin
			ax = ANGLE_INVALID;
			ay = ANGLE_INVALID;
		end else if (!fo.grad_ok) begin
			ax = ANGLE_MID;
			ay = ANGLE_MID;
		end else begin
			ax = fo.zero_x ? ANGLE_MID
				: fo.neg_x ? ANGLE_MID - ANGLE_W'(k_x) : ANGLE_MID + ANGLE_W'(k_x);
			ay = fo.zero_y ? ANGLE_MID
				: fo.neg_y ? ANGLE_MID - ANGLE_W'(k_y) : ANGLE_MID + ANGLE_W'(k_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= fo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {ay, ax};
		end
	end

	a_both_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[ANGLE_W-1:0] == ANGLE_INVALID)
			== (m_tdata[2*ANGLE_W-1:ANGLE_W] == ANGLE_INVALID)))
		else $error("only one angle marked invalid");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ANGLE_W-1:0] == ANGLE_INVALID
			|| (m_tdata[ANGLE_W-1:0] >= 8'd1 && m_tdata[ANGLE_W-1:0] <= 8'd179)))
		else $error("horizontal angle out of range");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*ANGLE_W-1:ANGLE_W] == ANGLE_INVALID
			|| (m_tdata[2*ANGLE_W-1:ANGLE_W] >= 8'd1
			&& m_tdata[2*ANGLE_W-1:ANGLE_W] <= 8'd179)))
		else $error("vertical angle out of range");

endmodule

@@ sim/tb_depth_slope_angle.sv @@
`timescale 1ns / 1ps

module tb_depth_slope_angle;
	import dsa_pkg::*;

	localparam int DB = DEPTH_BITS_DEF;
	localparam int SW = ((5*DB+MASK_W+EDGE_W+7)/8)*8;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [ANGLE_W-1:0] ax;
		logic [ANGLE_W-1:0] ay;
	} angles_t;

	class slope_scoreboard;
		angles_t pending[$];
		logic [CFG_W-1:0] thr, hsc, vsc;
		int mismatches;

		function void reset_regs();
			thr = THRESHOLD_RST;
			hsc = HSCALE_RST;
			vsc = VSCALE_RST;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_THRESHOLD: thr = v;
				REG_HSCALE: hsc = v;
				REG_VSCALE: vsc = v;
				default: ;
			endcase
		endfunction

		function logic [ANGLE_W-1:0] slope(longint a, longint b, logic [CFG_W-1:0] sc);
			longint diff, mag, mx, lhs, den;
			int k;
			diff = a - b;
			mag = diff < 0 ? -diff : diff;
			mx = a > b ? a : b;
			k = 0;
			if (mag == 0)
				return ANGLE_MID;
			lhs = mag * 65536 * 1000000;
			den = mx * longint'(sc);
			for (int j = 0; j < TAN_STEPS; j++)
				if (lhs >= longint'(TAN_MICRO[j]) * den)
					k++;
			return diff > 0 ? ANGLE_W'(ANGLE_MID + k) : ANGLE_W'(ANGLE_MID - k);
		endfunction

		function void note_input(logic [SW-1:0] d);
			longint c, n[4], v[4];
			logic [MASK_W-1:0] vm;
			logic [EDGE_W-1:0] em;
			logic miss[4];
			logic ok;
			angles_t e;
			c = d[DB-1:0];
			for (int i = 0; i < 4; i++)
				n[i] = d[(i+1)*DB +: DB];
			vm = d[5*DB +: MASK_W];
			em = d[5*DB+MASK_W +: EDGE_W];
			if (!vm[0]) begin
				e.ax = ANGLE_INVALID;
				e.ay = ANGLE_INVALID;
			end else begin
				for (int i = 0; i < 4; i++)
					miss[i] = em[i] || !vm[i+1];
				ok = 1;
				for (int i = 0; i < 4; i++) begin
					if (!miss[i]) begin
						v[i] = n[i];
					end else if (!miss[i^1]) begin
						v[i] = 2*c - n[i^1];
					end else begin
						v[i] = 0;
						ok = 0;
					end
					if (v[i] < longint'(thr))
						ok = 0;
				end
				if (ok) begin
					e.ax = slope(v[0], v[1], hsc);
					e.ay = slope(v[2], v[3], vsc);
				end else begin
					e.ax = ANGLE_MID;
					e.ay = ANGLE_MID;
				end
			end
			pending = {pending, e};
		endfunction

		function void check_result(logic [2*ANGLE_W-1:0] d);
			angles_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %0d %0d", d[7:0], d[15:8]);
				return;
			end
			e = pending.pop_front();
			if (d[ANGLE_W-1:0] !== e.ax || d[2*ANGLE_W-1:ANGLE_W] !== e.ay) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
						e.ax, e.ay, d[7:0], d[15:8]);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [2*ANGLE_W-1:0] m_tdata;

	slope_scoreboard board = new();
	bit calm = 0;
	int idle_cycles = 0;

	depth_slope_angle DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			m_tready <= calm || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[depth_slope_angle] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, v);
	endtask

	task automatic send_pixel(logic [SW-1:0] d);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_input(d);
	endtask

	task automatic drain();
		int n;
		n = 0;
		s_tvalid <= 0;
		while (board.pending.size() != 0 && n < IDLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [SW-1:0] pack(logic [15:0] c, l, r, u, d,
		logic [MASK_W-1:0] vm, logic [EDGE_W-1:0] em);
		logic [SW-1:0] p;
		p = '0;
		p[0 +: DB] = c;
		p[DB +: DB] = l;
		p[2*DB +: DB] = r;
		p[3*DB +: DB] = u;
		p[4*DB +: DB] = d;
		p[5*DB +: MASK_W] = vm;
		p[5*DB+MASK_W +: EDGE_W] = em;
		return p;
	endfunction

	function automatic logic [SW-1:0] random_pixel();
		logic [15:0] c, n[4];
		int sel, spread;
		sel = $urandom_range(9);
		if (sel < 2) begin
			return pack(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 5'($urandom), 4'($urandom));
		end
		c = 16'($urandom_range(65535, 300));
		spread = $urandom_range(3) == 0 ? int'(c) : int'(c) / 8 + 1;
		for (int i = 0; i < 4; i++)
			n[i] = 16'(int'(c) + $urandom_range(2*spread) - spread);
		return pack(c, n[0], n[1], n[2], n[3],
			$urandom_range(3) == 0 ? 5'($urandom) : 5'h1f,
			$urandom_range(3) == 0 ? 4'($urandom) : 4'h0);
	endfunction

	initial begin
		logic [CFG_W-1:0] th[4], hs[4], vs[4];
		th = '{16'd800, 16'd0, 16'hffff, 16'd100};
		hs = '{16'd415, 16'd1, 16'hffff, 16'd3000};
		vs = '{16'd429, 16'hffff, 16'd1, 16'd200};
		board.reset_regs();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		calm = 1;
		send_pixel(pack(1000, 1200, 900, 1100, 1000, 5'h1f, 4'h0));
		send_pixel(pack(1000, 1200, 900, 1100, 1000, 5'h1e, 4'h0));
		send_pixel(pack(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 5'h1f, 4'h0));
		send_pixel(pack(0, 0, 0, 0, 0, 5'h1f, 4'h0));
		send_pixel(pack(2000, 1500, 0, 3000, 0, 5'h1f, 4'h0));
		send_pixel(pack(2000, 1500, 0, 3000, 0, 5'h1b, 4'h0));
		send_pixel(pack(2000, 1500, 2500, 1800, 0, 5'h1f, 4'h9));
		send_pixel(pack(2000, 1500, 2500, 1800, 2200, 5'h1f, 4'h3));
		send_pixel(pack(2000, 1500, 2500, 1800, 2200, 5'h07, 4'h0));
		send_pixel(pack(500, 1500, 2500, 1800, 2200, 5'h1b, 4'h0));
		send_pixel(pack(5000, 900, 65535, 65535, 900, 5'h1f, 4'h0));
		send_pixel(pack(5000, 65535, 900, 900, 65535, 5'h1f, 4'h0));
		send_pixel(pack(3000, 3000, 3000, 2000, 4000, 5'h1f, 4'hf));
		send_pixel(pack(3000, 2900, 3100, 2000, 4000, 5'h15, 4'h4));
		calm = 0;

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			write_reg(REG_THRESHOLD, th[phase]);
			write_reg(REG_HSCALE, hs[phase]);
			write_reg(REG_VSCALE, vs[phase]);
			cfg_valid <= 0;
			send_pixel(pack(0, 0, 0, 0, 0, 5'h1f, 4'h0));
			send_pixel(pack(65535, 1, 65535, 65535, 1, 5'h1f, 4'h0));
			for (int i = 0; i < 320; i++) begin
				calm = (phase == 1 && i >= 100 && i < 250);
				send_pixel(random_pixel());
			end
			calm = 0;
		end
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("[depth_slope_angle] OK");
		else
			$display("[depth_slope_angle] ERROR");
		$finish;
	end

endmodule
